### rtl/bbe_pkg.sv
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared types and constants of the B-spline basis evaluator.
// ----------------------------------------------------------------------------
package bbe_pkg;

	localparam int NUM_KNOTS  = 256;
	localparam int MAX_DEGREE = 5;
	localparam int KNOT_AW    = $clog2(NUM_KNOTS);
	localparam int PADDR_W    = 3;

	localparam logic [2:0] DEGREE_RESET = 3'd3;
	localparam logic [PADDR_W-1:0] ADDR_DEGREE = '0;

	localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;
	localparam logic [62:0] TERM_LIM = 63'd4294967296;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EVAL  = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_GAP   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_READ,
		ST_GAP,
		ST_MUL,
		ST_DIV,
		ST_WAIT,
		ST_SAT,
		ST_EMIT,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] num;
		logic [31:0]        den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [33:0] quot;
	} div_rsp_t;

endpackage

### rtl/bbe_if.sv
// ----------------------------------------------------------------------------
// bbe_req_if / bbe_rsp_if
// Valid/ready channels carrying requests and basis results.
// ----------------------------------------------------------------------------
interface bbe_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  knot_index;
	logic signed [31:0] knot_value;
	logic signed [31:0] x_value;
	logic [7:0]  interval;

	modport source (output valid, req_type, knot_index, knot_value, x_value, interval,
		input ready);
	modport sink (input valid, req_type, knot_index, knot_value, x_value, interval,
		output ready);
endinterface

interface bbe_rsp_if;
	logic        valid;
	logic        ready;
	logic [30:0] basis_value;
	logic [2:0]  basis_index;
	logic        last;
	logic [1:0]  status;

	modport source (output valid, basis_value, basis_index, last, status, input ready);
	modport sink (input valid, basis_value, basis_index, last, status, output ready);
endinterface

### rtl/bbe_div.sv
// ----------------------------------------------------------------------------
// bbe_div
// Bit-serial signed divider, rounds to nearest (ties away from zero) and
// saturates the quotient to +-2^32. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbe_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bbe_pkg::div_req_t   req,
	output bbe_pkg::div_rsp_t   rsp
);
	import bbe_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [31:0] den_q;
	logic [62:0] num_q;
	logic [62:0] quo_q;
	logic [31:0] rem_q;

	logic [63:0] mag;
	logic [62:0] rnd;
	logic [32:0] rem_sh;
	logic        fits;
	logic [62:0] qsat;

	always_comb begin
		mag    = req.num[63] ? 64'(-req.num) : 64'(req.num);
		rnd    = mag[62:0] + {31'd0, req.den[31:1]};
		rem_sh = {rem_q, num_q[62]};
		fits   = rem_sh >= {1'b0, den_q};
		qsat   = (quo_q > TERM_LIM) ? TERM_LIM : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd62) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[63];
			den_q <= req.den;
			num_q <= rnd;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[61:0], 1'b0};
			quo_q <= {quo_q[61:0], fits};
			rem_q <= fits ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? 34'(-$signed({1'b0, qsat[32:0]})) : $signed({1'b0, qsat[32:0]});

endmodule

### rtl/bspline_basis_eval_core.sv
// ----------------------------------------------------------------------------
// bspline_basis_eval_core
// Cox-de Boor B-spline basis evaluator over a knot table in block memory.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_type 0 stores knot_value at knot_index (no result);
//   req_type 1 evaluates the degree-k basis at x_value in interval l.
//   rsp channel: k+1 results, basis_index 0..k, last set on the final one,
//   or a single result with status 1 (interval out of range) or 2
//   (nonpositive knot gap).
//   APB port: register 0 at address 0 holds the degree, reset 3.
// Throughput:
//   an evaluation emits its results at one result per cycle while the
//   receiver is ready; the bit-serial divider, used twice per recurrence
//   step, sets the wait before its first result. One request is worked at
//   a time.
// Reset:
//   control and degree register clear to their reset values; knot memory
//   contents are undefined until written.
// Stall:
//   results wait in an output register; a stalled receiver holds the block
//   in its emit phase, and a new request is taken once the last is loaded.
// ----------------------------------------------------------------------------
module bspline_basis_eval_core (
	input  logic                         clk,
	input  logic                         arst_n,
	bbe_req_if.sink                      req,
	bbe_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bbe_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import bbe_pkg::*;

	state_t state_q, state_d;

	logic [2:0]          degree_q;
	logic [2:0]          k_q;
	logic [KNOT_AW-1:0]  l_q;
	logic signed [31:0]  x_q;
	logic [2:0]          j_q;
	logic [2:0]          i_q;
	logic [2:0]          e_q;
	logic                phase_q;
	logic signed [31:0]  tr_q;
	logic signed [31:0]  tl_q;
	logic [31:0]         gap_q;
	logic signed [63:0]  prod_s1;
	logic signed [34:0]  h_q [MAX_DEGREE+1];
	logic [30:0]         hh_q [MAX_DEGREE+1];

	logic [31:0]         knot_mem [NUM_KNOTS];
	logic [31:0]         rd_r_q;
	logic [31:0]         rd_l_q;

	logic                in_ready;
	logic                in_acc;
	logic                out_free;
	logic                out_load;
	logic                mem_rd;
	logic                div_start;
	logic                out_valid_q;
	logic [30:0]         out_value_q;
	logic [2:0]          out_index_q;
	logic                out_last_q;
	logic [1:0]          out_status_q;

	logic [2:0]          k_eff;
	logic [KNOT_AW+1:0]  hi_sum;
	logic                range_bad;
	logic [KNOT_AW-1:0]  addr_r;
	logic [KNOT_AW-1:0]  addr_l;
	logic signed [32:0]  gap;
	logic                gap_bad;
	logic signed [32:0]  diff;
	logic signed [64:0]  prod_full;
	logic [30:0]         hh_sel;
	div_req_t            dreq;
	div_rsp_t            drsp;
	logic                cfg_wr;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr == ADDR_DEGREE) ? {29'd0, degree_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEGREE_RESET;
		end else if (cfg_wr && paddr == ADDR_DEGREE) begin
			degree_q <= pwdata[2:0];
		end
	end

	always_comb begin
		if (degree_q == 3'd0) begin
			k_eff = 3'd1;
		end else if (degree_q > 3'(MAX_DEGREE)) begin
			k_eff = 3'(MAX_DEGREE);
		end else begin
			k_eff = degree_q;
		end
		hi_sum    = {2'b0, req.interval[KNOT_AW-1:0]} + (KNOT_AW+2)'(k_eff);
		range_bad = (hi_sum > (KNOT_AW+2)'(NUM_KNOTS - 1)) ||
			({2'b0, req.interval[KNOT_AW-1:0]} < (KNOT_AW+2)'(k_eff - 3'd1));
		addr_r    = l_q + KNOT_AW'(i_q);
		addr_l    = l_q + KNOT_AW'(i_q) - KNOT_AW'(j_q);
		gap       = $signed({rd_r_q[31], rd_r_q}) - $signed({rd_l_q[31], rd_l_q});
		gap_bad   = gap[32] || (gap == 33'sd0);
		hh_sel    = hh_q[i_q - 3'd1];
		diff      = phase_q ? ($signed({x_q[31], x_q}) - $signed({tl_q[31], tl_q}))
			: ($signed({tr_q[31], tr_q}) - $signed({x_q[31], x_q}));
		prod_full = $signed({2'b0, hh_sel}) * diff;
	end

	// knot memory
	always_ff @(posedge clk) begin
		if (in_acc && req.req_type == REQ_WRITE) begin
			knot_mem[req.knot_index[KNOT_AW-1:0]] <= req.knot_value;
		end
		if (mem_rd) begin
			rd_r_q <= knot_mem[addr_r];
			rd_l_q <= knot_mem[addr_l];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && req.req_type == REQ_EVAL) begin
					state_d = range_bad ? ST_ERR : ST_LEVEL;
				end
			end
			ST_LEVEL: state_d = ST_READ;
			ST_READ:  state_d = ST_GAP;
			ST_GAP:   state_d = gap_bad ? ST_ERR : ST_MUL;
			ST_MUL:   state_d = ST_DIV;
			ST_DIV:   state_d = ST_WAIT;
			ST_WAIT: begin
				if (drsp.done) begin
					if (!phase_q) begin
						state_d = ST_MUL;
					end else if (i_q == j_q) begin
						state_d = ST_SAT;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_SAT:   state_d = (j_q == k_q) ? ST_EMIT : ST_LEVEL;
			ST_EMIT: begin
				if (out_free && e_q == k_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		mem_rd    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready  = 1'b1;
			ST_READ:  mem_rd    = 1'b1;
			ST_DIV:   div_start = 1'b1;
			ST_EMIT:  out_load  = out_free;
			ST_ERR:   out_load  = out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign req.ready = in_ready;
	assign in_acc    = req.valid & in_ready;
	assign out_free  = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// recurrence datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			i_q     <= '0;
			e_q     <= '0;
			phase_q <= 1'b0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						k_q <= k_eff;
						j_q <= range_bad ? 3'd0 : 3'd1;
						e_q <= '0;
					end
				end
				ST_LEVEL: begin
					i_q     <= 3'd1;
					phase_q <= 1'b0;
				end
				ST_WAIT: begin
					if (drsp.done) begin
						phase_q <= !phase_q;
						if (phase_q) begin
							i_q <= i_q + 3'd1;
						end
					end
				end
				ST_SAT: begin
					j_q <= j_q + 3'd1;
				end
				ST_EMIT: begin
					if (out_free) begin
						e_q <= e_q + 3'd1;
					end
				end
				default: begin
					phase_q <= phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					l_q    <= req.interval[KNOT_AW-1:0];
					x_q    <= req.x_value;
					h_q[0] <= ONE_Q30;
				end
			end
			ST_LEVEL: begin
				for (int n = 0; n <= MAX_DEGREE; n++) begin
					hh_q[n] <= h_q[n][30:0];
				end
				h_q[0] <= '0;
			end
			ST_GAP: begin
				tr_q  <= rd_r_q;
				tl_q  <= rd_l_q;
				gap_q <= gap[31:0];
			end
			ST_MUL: begin
				prod_s1 <= prod_full[63:0];
			end
			ST_WAIT: begin
				if (drsp.done) begin
					if (!phase_q) begin
						h_q[i_q - 3'd1] <= h_q[i_q - 3'd1] + {drsp.quot[33], drsp.quot};
					end else begin
						h_q[i_q] <= {drsp.quot[33], drsp.quot};
					end
				end
			end
			ST_SAT: begin
				for (int n = 0; n <= MAX_DEGREE; n++) begin
					if (h_q[n] < 35'sd0) begin
						h_q[n] <= '0;
					end else if (h_q[n] > ONE_Q30) begin
						h_q[n] <= ONE_Q30;
					end
				end
			end
			default: begin
				gap_q <= gap_q;
			end
		endcase
	end

	assign dreq.start = div_start;
	assign dreq.num   = prod_s1;
	assign dreq.den   = gap_q;

	bbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_ERR) begin
				out_value_q  <= '0;
				out_index_q  <= '0;
				out_last_q   <= 1'b1;
				out_status_q <= (j_q == 3'd0) ? STAT_RANGE : STAT_GAP;
			end else begin
				out_value_q  <= h_q[e_q][30:0];
				out_index_q  <= e_q;
				out_last_q   <= (e_q == k_q);
				out_status_q <= STAT_OK;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.basis_value = out_value_q;
	assign rsp.basis_index = out_index_q;
	assign rsp.last        = out_last_q;
	assign rsp.status      = out_status_q;

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STAT_OK |-> rsp.last && rsp.basis_value == 31'd0)
		else $error("error result without last");
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STAT_OK |-> rsp.basis_value <= 31'd1073741824)
		else $error("basis value above one");
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && req.req_type == REQ_EVAL |=> !req.ready)
		else $error("evaluate request did not start work");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == ST_WAIT)
		else $error("divider result outside wait");

endmodule
